// ===== hw/rtl/swa_pkg.sv =====
// Shared constants and types for the sliding window average block.
`default_nettype none

package swa_pkg;

    // Field widths of the request and result items.
    localparam int SAMPLE_W   = 16;
    localparam int WIN_W      = 5;
    localparam int FRAC_W     = 8;
    localparam int AVG_W      = 24;
    localparam int POS_W      = 16;
    localparam int OUT_DATA_W = AVG_W + POS_W;

    // Status that the window stage hands to the control logic.
    typedef struct packed {
        logic done;
        logic has_result;
    } t_win_status;

endpackage

`default_nettype wire

// ===== hw/rtl/swa_window.sv =====
// Sample window: circular sample memory, running sum, fill count and window position.
`default_nettype none

module swa_window
    import swa_pkg::*;
#(
    parameter int MAX_WINDOW = 20,
    localparam int SUM_W = SAMPLE_W + $clog2(MAX_WINDOW)
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_clear,
    input  wire logic                       i_start,
    input  wire logic [WIN_W-1:0]           i_win,
    input  wire logic signed [SAMPLE_W-1:0] i_sample,
    input  wire logic                       i_first,
    output t_win_status                     o_status,
    output logic signed [SUM_W-1:0]         o_sum,
    output logic [POS_W-1:0]                o_pos
);

    localparam int SLOT_W = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int CMP_W  = (SLOT_W > WIN_W) ? SLOT_W : WIN_W;

    logic signed [SAMPLE_W-1:0] r_mem [MAX_WINDOW];
    logic signed [SAMPLE_W-1:0] r_old;
    logic signed [SAMPLE_W-1:0] r_sample;
    logic signed [SUM_W-1:0]    r_sum;
    logic signed [SUM_W-1:0]    n_sum;
    logic [SUM_W-1:0]           w_old_ext;
    logic [WIN_W-1:0]           r_fill;
    logic [WIN_W-1:0]           w_new_fill;
    logic [SLOT_W-1:0]          r_slot;
    logic [SLOT_W-1:0]          r_cur;
    logic [SLOT_W-1:0]          w_start_slot;
    logic [SLOT_W-1:0]          w_next_slot;
    logic [POS_W-1:0]           r_index;
    logic [POS_W-1:0]           r_pos;
    logic                       r_busy;
    logic                       w_full;
    logic                       w_has;
    logic                       w_step;
    t_win_status                r_status;

    // Slot that the new sample goes to; a new series starts at slot zero.
    always_comb begin
        w_start_slot = i_first ? '0 : r_slot;
        if (CMP_W'(w_start_slot) >= CMP_W'(i_win)) begin
            w_start_slot = '0;
        end
    end

    // Update of the sum and fill count once the oldest sample has been read.
    always_comb begin
        w_full     = (r_fill >= i_win);
        w_new_fill = w_full ? r_fill : r_fill + WIN_W'(1);
        w_has      = (w_new_fill >= i_win);
        w_old_ext  = w_full ? SUM_W'(r_old) : '0;
        n_sum      = r_sum - $signed(w_old_ext) + SUM_W'(r_sample);
        if (CMP_W'(r_cur) + CMP_W'(1) >= CMP_W'(i_win)) begin
            w_next_slot = '0;
        end else begin
            w_next_slot = r_cur + SLOT_W'(1);
        end
    end

    // The second step of a request completes in this cycle.
    assign w_step = r_busy && !i_clear && !i_start;

    // Control state: counters, sum and the two-step sequence of one request.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum    <= '0;
            r_fill   <= '0;
            r_slot   <= '0;
            r_index  <= '0;
            r_busy   <= 1'b0;
            r_status <= '0;
        end else begin
            r_status.done       <= w_step;
            r_status.has_result <= w_step && w_has;
            if (i_clear) begin
                r_sum   <= '0;
                r_fill  <= '0;
                r_slot  <= '0;
                r_index <= '0;
            end else if (i_start) begin
                r_busy <= 1'b1;
                if (i_first) begin
                    r_sum   <= '0;
                    r_fill  <= '0;
                    r_slot  <= '0;
                    r_index <= '0;
                end
            end else if (r_busy) begin
                r_busy <= 1'b0;
                r_sum  <= n_sum;
                r_fill <= w_new_fill;
                r_slot <= w_next_slot;
                if (w_has && (r_index != '1)) begin
                    r_index <= r_index + POS_W'(1);
                end
            end
        end
    end

    // Sample memory: read the oldest sample on start, write the new one while the request is busy.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_cur    <= w_start_slot;
            r_sample <= i_sample;
            r_old    <= r_mem[w_start_slot];
        end
        if (r_busy) begin
            r_mem[r_cur] <= r_sample;
            r_pos        <= r_index;
        end
    end

    assign o_status = r_status;
    assign o_sum    = r_sum;
    assign o_pos    = r_pos;

endmodule

`default_nettype wire

// ===== hw/rtl/swa_divider.sv =====
// Bit-serial rounding divider: window sum times 256 over the window size.
`default_nettype none

module swa_divider
    import swa_pkg::*;
#(
    parameter int MAX_WINDOW = 20,
    localparam int SUM_W = SAMPLE_W + $clog2(MAX_WINDOW)
) (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_start,
    input  wire logic signed [SUM_W-1:0] i_sum,
    input  wire logic [WIN_W-1:0]        i_win,
    output logic                         o_valid,
    output logic [AVG_W-1:0]             o_quot
);

    // Dividend is 2 * |sum| * 256 + w, divisor is 2 * w.
    localparam int LOW_W = FRAC_W + 1;
    localparam int DIV_W = SUM_W + LOW_W;
    localparam int DVS_W = WIN_W + 1;
    localparam int CNT_W = $clog2(DIV_W + 1);

    logic [DIV_W-1:0] r_dvd;
    logic [DVS_W-1:0] r_dvs;
    logic [DVS_W-1:0] r_rem;
    logic [AVG_W-1:0] r_quot;
    logic [CNT_W-1:0] r_cnt;
    logic             r_neg;
    logic             r_run;
    logic             r_fix;
    logic             r_valid;
    logic [SUM_W-1:0] w_mag;
    logic [DVS_W:0]   w_trial;
    logic [DVS_W:0]   w_diff;
    logic             w_ge;

    // Magnitude of the sum; the sign is applied after the division.
    assign w_mag = i_sum[SUM_W-1] ? (~$unsigned(i_sum) + SUM_W'(1)) : $unsigned(i_sum);

    // One restoring step: shift in the next dividend bit and try the divisor.
    assign w_trial = {r_rem, r_dvd[DIV_W-1]};
    assign w_diff  = w_trial - {1'b0, r_dvs};
    assign w_ge    = (w_trial >= {1'b0, r_dvs});

    // Sequence control: one quotient bit per cycle, then a sign fix-up step before the result is valid.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run   <= 1'b0;
            r_fix   <= 1'b0;
            r_valid <= 1'b0;
            r_cnt   <= '0;
        end else begin
            if (i_start) begin
                r_run   <= 1'b1;
                r_fix   <= 1'b0;
                r_valid <= 1'b0;
                r_cnt   <= CNT_W'(DIV_W);
            end else if (r_run) begin
                r_cnt <= r_cnt - CNT_W'(1);
                if (r_cnt == CNT_W'(1)) begin
                    r_run <= 1'b0;
                    r_fix <= 1'b1;
                end
            end else if (r_fix) begin
                r_fix   <= 1'b0;
                r_valid <= 1'b1;
            end
        end
    end

    // Datapath shift registers for dividend, remainder and quotient.
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd  <= {w_mag, LOW_W'(i_win)};
            r_dvs  <= {i_win, 1'b0};
            r_rem  <= '0;
            r_quot <= '0;
            r_neg  <= i_sum[SUM_W-1];
        end else if (r_run) begin
            r_dvd  <= {r_dvd[DIV_W-2:0], 1'b0};
            r_rem  <= w_ge ? w_diff[DVS_W-1:0] : w_trial[DVS_W-1:0];
            r_quot <= {r_quot[AVG_W-2:0], w_ge};
        end else if (r_fix && r_neg) begin
            r_quot <= ~r_quot + AVG_W'(1);
        end
    end

    assign o_valid = r_valid;
    assign o_quot  = r_quot;

endmodule

`default_nettype wire

// ===== hw/rtl/sliding_window_average.sv =====
// Top level of the sliding window average: stream ports, control and result register.
`default_nettype none

// Moving average of signed 16-bit samples over the newest window_size samples
// (1 to MAX_WINDOW; a write of zero means 1, larger values are clipped to
// MAX_WINDOW). A write of the window size, or a request with tuser set, starts
// a new series. Once a series holds window_size samples, every request yields
// one result: the mean times 256, rounded to nearest with ties away from zero,
// and the position of the first sample of the window in the series. Nearly
// all of the time of a request goes to the bit-serial divider, which produces
// one quotient bit per cycle over SUM_W + 9 dividend bits, where SUM_W =
// 16 + clog2(MAX_WINDOW). A new request is taken while the previous result
// still waits in the output register.
module sliding_window_average
    import swa_pkg::*;
#(
    parameter int MAX_WINDOW = 20
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_wr_en,
    input  wire logic [WIN_W-1:0]      i_cfg_wr_data,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [SAMPLE_W-1:0]   s_axis_tdata,   // [15:0] sample
    input  wire logic                  s_axis_tuser,   // [0] first_of_series
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0]      m_axis_tdata    // [23:0] average, [39:24] position
);

    localparam int SUM_W = SAMPLE_W + $clog2(MAX_WINDOW);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_WIN,
        ST_DIV
    } t_state;

    t_state                  r_state;
    logic [WIN_W-1:0]        r_win;
    logic [WIN_W-1:0]        w_cfg_win;
    logic                    r_out_valid;
    logic [AVG_W-1:0]        r_avg;
    logic [POS_W-1:0]        r_pos;
    logic                    w_accept;
    logic                    w_div_start;
    logic                    w_div_valid;
    logic                    w_out_load;
    logic [AVG_W-1:0]        w_quot;
    t_win_status             w_stat;
    logic signed [SUM_W-1:0] w_sum;
    logic [POS_W-1:0]        w_pos;

    // Effective window size from the written value.
    always_comb begin
        if (i_cfg_wr_data == '0) begin
            w_cfg_win = WIN_W'(1);
        end else if (int'(i_cfg_wr_data) > MAX_WINDOW) begin
            w_cfg_win = WIN_W'(MAX_WINDOW);
        end else begin
            w_cfg_win = i_cfg_wr_data;
        end
    end

    assign s_axis_tready = (r_state == ST_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_div_start   = (r_state == ST_WIN) && w_stat.done && w_stat.has_result;
    assign w_out_load    = (r_state == ST_DIV) && w_div_valid
                           && (!r_out_valid || m_axis_tready);

    swa_window #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_window (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_clear  (i_cfg_wr_en),
        .i_start  (w_accept),
        .i_win    (r_win),
        .i_sample ($signed(s_axis_tdata)),
        .i_first  (s_axis_tuser),
        .o_status (w_stat),
        .o_sum    (w_sum),
        .o_pos    (w_pos)
    );

    swa_divider #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_sum   (w_sum),
        .i_win   (r_win),
        .o_valid (w_div_valid),
        .o_quot  (w_quot)
    );

    // Request sequencing and the output result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_win       <= WIN_W'(1);
        end else begin
            if (i_cfg_wr_en) begin
                r_win <= w_cfg_win;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
                r_avg       <= w_quot;
                r_pos       <= w_pos;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                ST_IDLE: begin
                    if (w_accept) begin
                        r_state <= ST_WIN;
                    end
                end
                ST_WIN: begin
                    if (w_stat.done) begin
                        r_state <= w_stat.has_result ? ST_DIV : ST_IDLE;
                    end
                end
                ST_DIV: begin
                    if (w_out_load) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: begin
                    r_state <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_pos, r_avg};

    // The window stage reports completion only while the control waits for it.
    a_win_done_expected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_stat.done |-> (r_state == ST_WIN))
        else $error("window stage finished outside of a request");

    // The effective window size always lies between one and the maximum.
    a_win_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_win != '0) && (int'(r_win) <= MAX_WINDOW))
        else $error("effective window size out of range");

    // Starting a division withdraws the previous quotient.
    a_div_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_start |=> !w_div_valid)
        else $error("divider shows a stale quotient after start");

endmodule

`default_nettype wire
